// ===== rtl/cdad_pkg.sv =====
`timescale 1ns / 1ps

package cdad_pkg;

  // field widths
  localparam int unsigned YEAR_W   = 14;
  localparam int unsigned MONTH_W  = 4;
  localparam int unsigned DAY_W    = 5;
  localparam int unsigned ADD_W    = 10;
  localparam int unsigned STATUS_W = 2;

  // internal widths: one spare year bit for overflow, day sum up to 31 + 1023
  localparam int unsigned YEAR_IW = YEAR_W + 1;
  localparam int unsigned SUM_W   = ADD_W + 1;
  localparam int unsigned QUOT_W  = 10;
  localparam int unsigned REM25_W = 5;

  // divide by 25 through a reciprocal: q = (y * 5243) >> 17, exact for y below 2^15
  localparam int unsigned DIV25_MUL_W = 13;
  localparam logic [DIV25_MUL_W-1:0] DIV25_MUL = 13'd5243;
  localparam int unsigned DIV25_SHIFT = 17;
  localparam int unsigned PROD_W = YEAR_W + DIV25_MUL_W;
  localparam logic [REM25_W-1:0] REM25_LAST = 5'd24;

  // months
  localparam logic [MONTH_W-1:0] MONTH_JAN = 4'd1;
  localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
  localparam logic [MONTH_W-1:0] MONTH_AUG = 4'd8;
  localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;

  // month lengths
  localparam logic [DAY_W-1:0] LEN_28 = 5'd28;
  localparam logic [DAY_W-1:0] LEN_29 = 5'd29;
  localparam logic [DAY_W-1:0] LEN_30 = 5'd30;
  localparam logic [DAY_W-1:0] LEN_31 = 5'd31;

  // status codes
  localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] ST_BAD_DATE = 2'd1;
  localparam logic [STATUS_W-1:0] ST_YEAR_OVF = 2'd2;

  typedef struct packed {
    logic [YEAR_W-1:0]  start_year;
    logic [MONTH_W-1:0] start_month;
    logic [DAY_W-1:0]   start_day;
    logic [ADD_W-1:0]   days_to_add;
  } in_item_t;

  typedef struct packed {
    logic [YEAR_W-1:0]   result_year;
    logic [MONTH_W-1:0]  result_month;
    logic [DAY_W-1:0]    result_day;
    logic [STATUS_W-1:0] status;
  } res_item_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_RECIP,
    S_CHECK,
    S_WALK
  } state_e;

  // sequencer controls to the datapath
  typedef struct packed {
    logic load;
    logic recip;
    logic init_walk;
    logic step;
    logic finish_ok;
    logic finish_bad;
  } ctrl_t;

endpackage

// ===== rtl/cdad_mlen.sv =====
`timescale 1ns / 1ps

module cdad_mlen (
  input  logic [cdad_pkg::MONTH_W-1:0] month_i,
  input  logic [3:0]                   year_lo_i,
  input  logic                         rem25_zero_i,
  output logic [cdad_pkg::DAY_W-1:0]   len_o
);

  logic leap;

  // leap: divisible by 4, and not by 100 unless by 400 (by 16 and by 25)
  assign leap = (year_lo_i[1:0] == 2'd0) && (!rem25_zero_i || (year_lo_i[3:2] == 2'd0));

  // month length, invalid month codes give 30 or 31 and are caught by the range check
  always_comb begin
    if (month_i == cdad_pkg::MONTH_FEB) begin
      len_o = leap ? cdad_pkg::LEN_29 : cdad_pkg::LEN_28;
    end else if ((month_i < cdad_pkg::MONTH_AUG) == month_i[0]) begin
      len_o = cdad_pkg::LEN_31;
    end else begin
      len_o = cdad_pkg::LEN_30;
    end
  end

endmodule

// ===== rtl/cdad_alu.sv =====
`timescale 1ns / 1ps

module cdad_alu (
  input  logic [cdad_pkg::SUM_W-1:0] a_i,
  input  logic [cdad_pkg::SUM_W-1:0] b_i,
  output logic [cdad_pkg::SUM_W-1:0] diff_o,
  output logic                       le_o
);

  logic borrow;

  // shared subtract and compare: a - b, and a <= b
  assign {borrow, diff_o} = {1'b0, a_i} - {1'b0, b_i};
  assign le_o = borrow || (diff_o == '0);

endmodule

// ===== rtl/calendar_date_add_days.sv =====
`timescale 1ns / 1ps

// channel   dir  ports                      meaning
// item      in   start_i, busy_o, item_i    start date and day count
// result    out  valid_o, res_o             date and status, one-cycle strobe
//
// one item runs through the reciprocal, check and walk states from accept to the result
// strobe; the walk steps over at most 34 months for a count of 1023, and takes one
// month per cycle through the single subtract/compare unit.
// an invalid start date gives its result from the check state, with no walk.
// reset clears the sequencer and the result strobe; results cannot be stalled.
module calendar_date_add_days (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  output logic                  busy_o,
  input  cdad_pkg::in_item_t    item_i,
  output logic                  valid_o,
  output cdad_pkg::res_item_t   res_o
);

  cdad_pkg::state_e state_q, state_d;
  cdad_pkg::ctrl_t  ctrl;

  logic [cdad_pkg::YEAR_IW-1:0] year_q;
  logic [cdad_pkg::MONTH_W-1:0] month_q;
  logic [cdad_pkg::SUM_W-1:0]   day_q;
  logic [cdad_pkg::ADD_W-1:0]   add_q;
  logic [cdad_pkg::QUOT_W-1:0]  quot_q;
  logic [cdad_pkg::REM25_W-1:0] rem25_q;
  cdad_pkg::res_item_t          res_q;
  logic                         valid_q;

  logic [cdad_pkg::PROD_W-1:0]  prod;
  logic [cdad_pkg::YEAR_IW-1:0] quot25x;
  logic [cdad_pkg::YEAR_IW-1:0] rem_full;
  logic [cdad_pkg::REM25_W-1:0] rem25_cur;
  logic [cdad_pkg::DAY_W-1:0]   len;
  logic [cdad_pkg::SUM_W-1:0]   diff;
  logic                         le;
  logic                         date_ok;
  logic                         month_ok;
  logic                         year_roll;

  // quotient by 25 through the reciprocal product
  assign prod = cdad_pkg::PROD_W'(year_q[cdad_pkg::YEAR_W-1:0]) *
                cdad_pkg::PROD_W'(cdad_pkg::DIV25_MUL);

  // remainder by 25 from the registered quotient
  assign quot25x  = (cdad_pkg::YEAR_IW'(quot_q) << 4) + (cdad_pkg::YEAR_IW'(quot_q) << 3) +
                    cdad_pkg::YEAR_IW'(quot_q);
  assign rem_full = year_q - quot25x;
  assign rem25_cur = (state_q == cdad_pkg::S_CHECK) ? rem_full[cdad_pkg::REM25_W-1:0] : rem25_q;

  cdad_mlen u_mlen (
    .month_i      (month_q),
    .year_lo_i    (year_q[3:0]),
    .rem25_zero_i (rem25_cur == '0),
    .len_o        (len)
  );

  cdad_alu u_alu (
    .a_i    (day_q),
    .b_i    (cdad_pkg::SUM_W'(len)),
    .diff_o (diff),
    .le_o   (le)
  );

  // start date check
  always_comb begin
    month_ok = month_q inside {[cdad_pkg::MONTH_JAN:cdad_pkg::MONTH_DEC]};
    date_ok  = month_ok && (day_q != '0) && le;
  end

  assign year_roll = (month_q == cdad_pkg::MONTH_DEC);

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      cdad_pkg::S_IDLE: begin
        if (start_i) state_d = cdad_pkg::S_RECIP;
      end
      cdad_pkg::S_RECIP: begin
        state_d = cdad_pkg::S_CHECK;
      end
      cdad_pkg::S_CHECK: begin
        state_d = date_ok ? cdad_pkg::S_WALK : cdad_pkg::S_IDLE;
      end
      cdad_pkg::S_WALK: begin
        if (le) state_d = cdad_pkg::S_IDLE;
      end
      default: state_d = cdad_pkg::S_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    ctrl = '0;
    case (state_q)
      cdad_pkg::S_IDLE: begin
        ctrl.load = start_i;
      end
      cdad_pkg::S_RECIP: begin
        ctrl.recip = 1'b1;
      end
      cdad_pkg::S_CHECK: begin
        ctrl.init_walk  = date_ok;
        ctrl.finish_bad = !date_ok;
      end
      cdad_pkg::S_WALK: begin
        ctrl.step      = !le;
        ctrl.finish_ok = le;
      end
      default: ctrl = '0;
    endcase
  end

  // sequencer state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= cdad_pkg::S_IDLE;
      valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      valid_q <= ctrl.finish_ok || ctrl.finish_bad;
    end
  end

  // date datapath
  always_ff @(posedge clk_i) begin
    if (ctrl.load) begin
      year_q  <= cdad_pkg::YEAR_IW'(item_i.start_year);
      month_q <= item_i.start_month;
      day_q   <= cdad_pkg::SUM_W'(item_i.start_day);
      add_q   <= item_i.days_to_add;
    end
    if (ctrl.recip) begin
      quot_q <= prod[cdad_pkg::DIV25_SHIFT +: cdad_pkg::QUOT_W];
    end
    if (ctrl.init_walk) begin
      rem25_q <= rem25_cur;
      day_q   <= day_q + cdad_pkg::SUM_W'(add_q);
    end
    // take one whole month off
    if (ctrl.step) begin
      day_q <= diff;
      if (year_roll) begin
        month_q <= cdad_pkg::MONTH_JAN;
        year_q  <= year_q + 1'b1;
        rem25_q <= (rem25_q == cdad_pkg::REM25_LAST) ? '0 : rem25_q + 1'b1;
      end else begin
        month_q <= month_q + 1'b1;
      end
    end
  end

  // result register
  always_ff @(posedge clk_i) begin
    if (ctrl.finish_bad) begin
      res_q.result_year  <= '0;
      res_q.result_month <= '0;
      res_q.result_day   <= '0;
      res_q.status       <= cdad_pkg::ST_BAD_DATE;
    end else if (ctrl.finish_ok) begin
      res_q.result_year  <= year_q[cdad_pkg::YEAR_W-1:0];
      res_q.result_month <= month_q;
      res_q.result_day   <= day_q[cdad_pkg::DAY_W-1:0];
      res_q.status       <= year_q[cdad_pkg::YEAR_W] ? cdad_pkg::ST_YEAR_OVF : cdad_pkg::ST_OK;
    end
  end

  assign busy_o  = (state_q != cdad_pkg::S_IDLE);
  assign valid_o = valid_q;
  assign res_o   = res_q;

endmodule
